>>> rtl/core/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg: shared types and constants
// Coefficient bundle, side data and divider word shared by the barometer
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CsrTempCoeffs = 2'd0;
   localparam logic [1:0] CsrPressLow   = 2'd1;
   localparam logic [1:0] CsrPressHigh  = 2'd2;
   localparam logic [1:0] CsrPressNine  = 2'd3;

   // Fixed compensation constants
   localparam int          FineOffset = 128000;
   localparam int          PressScale = 3125;
   localparam int          PressBase  = 1048576;
   localparam logic [63:0] PressBias  = 64'h0000_8000_0000_0000;

   // Quotient bits, one divider stage each
   localparam int DivBits = 64;

   // Port widths
   localparam int ReqDataW = 40;
   localparam int RspDataW = 128;

   // Factory coefficients, all raw 16-bit slices
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   // Temperature results that ride along with the pressure word
   typedef struct packed {
      logic signed [31:0] t_fine;
      logic signed [31:0] temp;
   } tside_type;

   // Word moving through the divider stages
   typedef struct packed {
      tside_type   side;
      logic        neg;
      logic        bad;
      logic [30:0] divisor;
      logic [30:0] rem;
      logic [63:0] qd;
   } div_type;

endpackage

`default_nettype wire

>>> rtl/core/bptc_temp.sv
// ----------------------------------------------------------------------------
// bptc_temp: temperature compensation stages
// Four stages from the raw temperature to t_fine, the centi-degree value and
// the offset fine temperature that starts the pressure path.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_temp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [19:0]         adc_p,
   input  wire logic [19:0]         adc_t,
   input  wire bptc_pkg::coeff_type coeff,
   output logic                     out_valid,
   output bptc_pkg::tside_type      out_side,
   output logic signed [32:0]       out_v1,
   output logic [19:0]              out_adcp
);

   logic [3:0]         vld_ff, vld_in;
   logic [19:0]        adcp_ff [4];
   logic [19:0]        adcp_in [4];
   logic signed [31:0] m1_ff, m1_in, dd_ff, dd_in;
   logic signed [31:0] tv1_ff, tv1_in, m2_ff, m2_in;
   logic signed [31:0] tf_ff, tf_in;
   logic signed [31:0] tf4_ff, tf4_in, temp_ff, temp_in;
   logic signed [32:0] v1_ff, v1_in;
   logic [31:0]        diff_a, diff_d;
   logic signed [31:0] dd_shr;

   // valid bits follow the data
   assign vld_in = {vld_ff[2:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // raw pressure carried to the pressure path
   assign adcp_in[0] = adc_p;
   assign adcp_in[1] = adcp_ff[0];
   assign adcp_in[2] = adcp_ff[1];
   assign adcp_in[3] = adcp_ff[2];

   // stage 1: offsets and first products
   assign diff_a = {15'd0, adc_t[19:3]} - {15'd0, coeff.t1, 1'b0};
   assign diff_d = {16'd0, adc_t[19:4]} - {16'd0, coeff.t1};
   assign m1_in  = $signed(diff_a) * 32'($signed(coeff.t2));
   assign dd_in  = $signed(diff_d * diff_d);

   // stage 2: second products
   assign dd_shr = dd_ff >>> 12;
   assign tv1_in = m1_ff >>> 11;
   assign m2_in  = dd_shr * 32'($signed(coeff.t3));

   // stage 3: t_fine
   assign tf_in = tv1_ff + (m2_ff >>> 14);

   // stage 4: centi-degrees and pressure offset
   assign tf4_in  = tf_ff;
   assign temp_in = ((tf_ff <<< 2) + tf_ff + 32'sd128) >>> 8;
   assign v1_in   = 33'(tf_ff) - 33'(bptc_pkg::FineOffset);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            adcp_ff[i] <= adcp_in[i];
         end
         m1_ff   <= m1_in;
         dd_ff   <= dd_in;
         tv1_ff  <= tv1_in;
         m2_ff   <= m2_in;
         tf_ff   <= tf_in;
         tf4_ff  <= tf4_in;
         temp_ff <= temp_in;
         v1_ff   <= v1_in;
      end
   end

   assign out_valid       = vld_ff[3];
   assign out_side.t_fine = tf4_ff;
   assign out_side.temp   = temp_ff;
   assign out_v1          = v1_ff;
   assign out_adcp        = adcp_ff[3];

endmodule

`default_nettype wire

>>> rtl/core/bptc_press_pre.sv
// ----------------------------------------------------------------------------
// bptc_press_pre: pressure path ahead of the divider
// Seven stages that form the dividend and divisor in 64-bit wrapping
// arithmetic, with wide products split into 32-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_press_pre (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire bptc_pkg::tside_type in_side,
   input  wire logic signed [32:0]  in_v1,
   input  wire logic [19:0]         in_adcp,
   input  wire bptc_pkg::coeff_type coeff,
   output logic                     out_valid,
   output bptc_pkg::div_type        out_div
);

   logic [6:0]          vld_ff, vld_in;
   bptc_pkg::tside_type side_ff [6];
   bptc_pkg::tside_type side_in [6];
   logic [19:0]         adcp_ff [3];
   logic [19:0]         adcp_in [3];

   logic [63:0]         sq_ff, sq_in;
   logic signed [48:0]  a5_ff, a5_in, a2_ff, a2_in;
   logic signed [48:0]  l6_ff, l6_in, l3_ff, l3_in, a5b_ff, a5b_in, a2b_ff, a2b_in;
   logic [31:0]         h6_ff, h6_in, h3_ff, h3_in;
   logic [63:0]         v2_ff, v2_in;
   logic signed [63:0]  pv1_ff, pv1_in;
   logic [63:0]         x_ff, x_in, n_ff, n_in;
   logic [47:0]         xl_ff, xl_in;
   logic [43:0]         nl_ff, nl_in;
   logic [31:0]         xh_ff, xh_in, nh_ff, nh_in;
   logic [30:0]         v1d_ff, v1d_in;
   logic [63:0]         num_ff, num_in;
   bptc_pkg::div_type   div_ff, div_in;

   logic signed [65:0]  sq_full;
   logic signed [63:0]  s3;
   logic [20:0]         base;
   logic [63:0]         xp;

   assign vld_in = {vld_ff[5:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // side data and raw pressure carried along
   always_comb begin
      side_in[0] = in_side;
      adcp_in[0] = in_adcp;
      for (int i = 1; i < 6; i++) begin
         side_in[i] = side_ff[i-1];
      end
      for (int i = 1; i < 3; i++) begin
         adcp_in[i] = adcp_ff[i-1];
      end
   end

   // stage 1: square and linear terms
   assign sq_full = in_v1 * in_v1;
   assign sq_in   = sq_full[63:0];
   assign a5_in   = in_v1 * $signed(coeff.p5);
   assign a2_in   = in_v1 * $signed(coeff.p2);

   // stage 2: square times P6 and P3, in halves
   assign l6_in  = $signed({1'b0, sq_ff[31:0]}) * $signed(coeff.p6);
   assign h6_in  = 32'($signed(sq_ff[63:32]) * $signed(coeff.p6));
   assign l3_in  = $signed({1'b0, sq_ff[31:0]}) * $signed(coeff.p3);
   assign h3_in  = 32'($signed(sq_ff[63:32]) * $signed(coeff.p3));
   assign a5b_in = a5_ff;
   assign a2b_in = a2_ff;

   // stage 3: sum up var2 and the first var1
   assign v2_in = 64'(l6_ff) + {h6_ff, 32'd0} + (64'(a5b_ff) << 17)
                + (64'($signed(coeff.p4)) << 35);
   assign s3     = $signed(64'(l3_ff) + {h3_ff, 32'd0});
   assign pv1_in = (s3 >>> 8) + (64'(a2b_ff) <<< 12);

   // stage 4: bias var1, form the pressure numerator
   assign base = 21'(bptc_pkg::PressBase) - {1'b0, adcp_ff[2]};
   assign x_in = bptc_pkg::PressBias + pv1_ff;
   assign n_in = {12'd0, base, 31'd0} - v2_ff;

   // stage 5: times P1 and 3125, in halves
   assign xl_in = x_ff[31:0] * coeff.p1;
   assign xh_in = 32'(x_ff[63:32] * {16'd0, coeff.p1});
   assign nl_in = n_ff[31:0] * 12'(bptc_pkg::PressScale);
   assign nh_in = 32'(n_ff[63:32] * 32'(bptc_pkg::PressScale));

   // stage 6: merge halves, divisor is var1 >> 33
   assign xp     = 64'(xl_ff) + {xh_ff, 32'd0};
   assign v1d_in = xp[63:33];
   assign num_in = 64'(nl_ff) + {nh_ff, 32'd0};

   // stage 7: magnitudes and quotient sign
   always_comb begin
      div_in.side    = side_ff[5];
      div_in.neg     = num_ff[63] ^ v1d_ff[30];
      div_in.bad     = (v1d_ff == 31'd0);
      div_in.divisor = v1d_ff[30] ? (31'd0 - v1d_ff) : v1d_ff;
      div_in.rem     = '0;
      div_in.qd      = num_ff[63] ? (64'd0 - num_ff) : num_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            side_ff[i] <= side_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            adcp_ff[i] <= adcp_in[i];
         end
         sq_ff  <= sq_in;
         a5_ff  <= a5_in;
         a2_ff  <= a2_in;
         l6_ff  <= l6_in;
         h6_ff  <= h6_in;
         l3_ff  <= l3_in;
         h3_ff  <= h3_in;
         a5b_ff <= a5b_in;
         a2b_ff <= a2b_in;
         v2_ff  <= v2_in;
         pv1_ff <= pv1_in;
         x_ff   <= x_in;
         n_ff   <= n_in;
         xl_ff  <= xl_in;
         xh_ff  <= xh_in;
         nl_ff  <= nl_in;
         nh_ff  <= nh_in;
         v1d_ff <= v1d_in;
         num_ff <= num_in;
         div_ff <= div_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_div   = div_ff;

endmodule

`default_nettype wire

>>> rtl/core/bptc_div_stage.sv
// ----------------------------------------------------------------------------
// bptc_div_stage: one restoring division step
// Shifts one dividend bit into the partial remainder and one quotient bit
// into the word, then registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_div_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire bptc_pkg::div_type in_div,
   output logic                   out_valid,
   output bptc_pkg::div_type      out_div
);

   logic              vld_ff;
   bptc_pkg::div_type div_ff, div_in;
   logic [31:0]       shifted;
   logic [32:0]       trial;
   logic              ge;

   // trial subtract of the divisor
   assign shifted = {in_div.rem, in_div.qd[63]};
   assign trial   = {1'b0, shifted} - {2'b0, in_div.divisor};
   assign ge      = !trial[32];

   always_comb begin
      div_in     = in_div;
      div_in.rem = ge ? trial[30:0] : shifted[30:0];
      div_in.qd  = {in_div.qd[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_div   = div_ff;

endmodule

`default_nettype wire

>>> rtl/core/bptc_press_post.sv
// ----------------------------------------------------------------------------
// bptc_press_post: pressure path after the divider
// Seven stages: signed quotient, P9 and P8 corrections, P7 offset, the
// scaled value and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_press_post (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire bptc_pkg::div_type   in_div,
   input  wire bptc_pkg::coeff_type coeff,
   output logic                     out_valid,
   output bptc_pkg::tside_type      out_side,
   output logic [31:0]              out_pq,
   output logic [31:0]              out_scaled,
   output logic                     out_bad
);

   logic [6:0]          vld_ff, vld_in;
   bptc_pkg::tside_type side_ff [7];
   bptc_pkg::tside_type side_in [7];
   logic                bad_ff [7];
   logic                bad_in [7];

   logic signed [63:0]  q_ff, q_in, q2_ff, q2_in, q3_ff, q3_in, q4_ff, q4_in;
   logic [63:0]         ll_ff, ll_in;
   logic [31:0]         lh_ff, lh_in, w2h_ff, w2h_in, mh_ff, mh_in;
   logic signed [48:0]  w2l_ff, w2l_in, ml_ff, ml_in;
   logic [63:0]         sqp_ff, sqp_in;
   logic signed [63:0]  w2_ff, w2_in, w2b_ff, w2b_in, s_ff, s_in;
   logic [31:0]         pq_ff, pq_in, pqo_ff, pqo_in, sc_ff, sc_in;

   logic signed [63:0]  ps, w1_sum;
   logic [31:0]         x100;

   assign vld_in = {vld_ff[5:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      side_in[0] = in_div.side;
      bad_in[0]  = in_div.bad;
      for (int i = 1; i < 7; i++) begin
         side_in[i] = side_ff[i-1];
         bad_in[i]  = bad_ff[i-1];
      end
   end

   // stage 1: apply quotient sign
   assign q_in = in_div.neg ? $signed(64'd0 - in_div.qd) : $signed(in_div.qd);

   // stage 2: square of p >> 13 and P8 term, in halves
   assign ps     = q_ff >>> 13;
   assign ll_in  = ps[31:0] * ps[31:0];
   assign lh_in  = ps[31:0] * ps[63:32];
   assign w2l_in = $signed({1'b0, q_ff[31:0]}) * $signed(coeff.p8);
   assign w2h_in = 32'($signed(q_ff[63:32]) * $signed(coeff.p8));
   assign q2_in  = q_ff;

   // stage 3: merge halves
   assign sqp_in = ll_ff + {lh_ff[30:0], 1'b0, 32'd0};
   assign w2_in  = $signed(64'(w2l_ff) + {w2h_ff, 32'd0});
   assign q3_in  = q2_ff;

   // stage 4: square times P9, in halves
   assign ml_in  = $signed({1'b0, sqp_ff[31:0]}) * $signed(coeff.p9);
   assign mh_in  = 32'($signed(sqp_ff[63:32]) * $signed(coeff.p9));
   assign w2b_in = w2_ff;
   assign q4_in  = q3_ff;

   // stage 5: p + var1 + var2
   assign w1_sum = $signed(64'(ml_ff) + {mh_ff, 32'd0});
   assign s_in   = q4_ff + (w1_sum >>> 25) + (w2b_ff >>> 19);

   // stage 6: scale down, add P7 offset
   assign pq_in = 32'((s_ff >>> 8) + (64'($signed(coeff.p7)) <<< 4));

   // stage 7: output register, zero pressure on a bad divisor
   assign x100   = (pq_ff << 6) + (pq_ff << 5) + (pq_ff << 2);
   assign pqo_in = bad_ff[5] ? 32'd0 : pq_ff;
   assign sc_in  = bad_ff[5] ? 32'd0 : {8'd0, x100[31:8]};

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 7; i++) begin
            side_ff[i] <= side_in[i];
            bad_ff[i]  <= bad_in[i];
         end
         q_ff   <= q_in;
         ll_ff  <= ll_in;
         lh_ff  <= lh_in;
         w2l_ff <= w2l_in;
         w2h_ff <= w2h_in;
         q2_ff  <= q2_in;
         sqp_ff <= sqp_in;
         w2_ff  <= w2_in;
         q3_ff  <= q3_in;
         ml_ff  <= ml_in;
         mh_ff  <= mh_in;
         w2b_ff <= w2b_in;
         q4_ff  <= q4_in;
         s_ff   <= s_in;
         pq_ff  <= pq_in;
         pqo_ff <= pqo_in;
         sc_ff  <= sc_in;
      end
   end

   assign out_valid  = vld_ff[6];
   assign out_side   = side_ff[6];
   assign out_bad    = bad_ff[6];
   assign out_pq     = pqo_ff;
   assign out_scaled = sc_ff;

endmodule

`default_nettype wire

>>> rtl/core/baro_temp_press_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core: barometer compensation pipeline
// Raw 20-bit pressure and temperature in, compensated temperature and
// 64-bit-path pressure out, one sample pair per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per sample pair (raw pressure, raw temperature).
//   rsp_*  : one word per sample pair, in order; tuser flags a zero divisor,
//            in which case both pressure fields read zero.
//   csr_*  : coefficient writes, to be taken only while the pipeline is empty;
//            the user must ensure this, as the block does not enforce it.
// 4 temperature stages, 7 stages ahead of the divider, 64 restoring divider
// stages (one quotient bit each) and 7 after, the last the output register.
// Throughput is one word per cycle unless stalled; the divider sets latency.
// The whole pipeline advances when the output register is empty or being
// taken; when the receiver stalls, every stage holds and req_tready drops.
// Reset clears all valid bits and the coefficient registers.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_press_compensation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // raw_pressure [19:0], raw_temperature [39:20]
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // fine_temperature [31:0], temperature_centi [63:32],
   // pressure_q24_8 [95:64], pressure_scaled [127:96]
   output logic [127:0]     rsp_tdata,
   // pressure_invalid [0]
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   logic [47:0]         tc_ff, tc_in;
   logic [63:0]         pl_ff, pl_in, ph_ff, ph_in;
   logic [15:0]         p9_ff, p9_in;
   bptc_pkg::coeff_type coeff;

   logic                pipe_en;
   logic                t_vld, pre_vld;
   bptc_pkg::tside_type t_side, o_side;
   logic signed [32:0]  t_v1;
   logic [19:0]         t_adcp;
   bptc_pkg::div_type   div_bus [bptc_pkg::DivBits+1];
   logic [bptc_pkg::DivBits:0] div_vld;
   logic [31:0]         o_pq, o_scaled;
   logic                o_bad;

   // coefficient registers
   always_comb begin
      tc_in = tc_ff;
      pl_in = pl_ff;
      ph_in = ph_ff;
      p9_in = p9_ff;
      if (csr_we) begin
         case (csr_index)
            bptc_pkg::CsrTempCoeffs: tc_in = csr_wdata[47:0];
            bptc_pkg::CsrPressLow:   pl_in = csr_wdata;
            bptc_pkg::CsrPressHigh:  ph_in = csr_wdata;
            bptc_pkg::CsrPressNine:  p9_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0;
         pl_ff <= '0;
         ph_ff <= '0;
         p9_ff <= '0;
      end else begin
         tc_ff <= tc_in;
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         p9_ff <= p9_in;
      end
   end

   assign coeff.t1 = tc_ff[15:0];
   assign coeff.t2 = tc_ff[31:16];
   assign coeff.t3 = tc_ff[47:32];
   assign coeff.p1 = pl_ff[15:0];
   assign coeff.p2 = pl_ff[31:16];
   assign coeff.p3 = pl_ff[47:32];
   assign coeff.p4 = pl_ff[63:48];
   assign coeff.p5 = ph_ff[15:0];
   assign coeff.p6 = ph_ff[31:16];
   assign coeff.p7 = ph_ff[47:32];
   assign coeff.p8 = ph_ff[63:48];
   assign coeff.p9 = p9_ff;

   // global advance: output register empty or being drained
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   bptc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .adc_p     (req_tdata[19:0]),
      .adc_t     (req_tdata[39:20]),
      .coeff     (coeff),
      .out_valid (t_vld),
      .out_side  (t_side),
      .out_v1    (t_v1),
      .out_adcp  (t_adcp)
   );

   bptc_press_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (t_vld),
      .in_side   (t_side),
      .in_v1     (t_v1),
      .in_adcp   (t_adcp),
      .coeff     (coeff),
      .out_valid (pre_vld),
      .out_div   (div_bus[0])
   );

   assign div_vld[0] = pre_vld;

   // divider chain, one quotient bit per stage
   for (genvar i = 0; i < bptc_pkg::DivBits; i++) begin : g_div
      bptc_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (div_vld[i]),
         .in_div    (div_bus[i]),
         .out_valid (div_vld[i+1]),
         .out_div   (div_bus[i+1])
      );
   end

   bptc_press_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (div_vld[bptc_pkg::DivBits]),
      .in_div     (div_bus[bptc_pkg::DivBits]),
      .coeff      (coeff),
      .out_valid  (rsp_tvalid),
      .out_side   (o_side),
      .out_pq     (o_pq),
      .out_scaled (o_scaled),
      .out_bad    (o_bad)
   );

   assign rsp_tdata = {o_scaled, o_pq, o_side.temp, o_side.t_fine};
   assign rsp_tuser = o_bad;

   // a stall freezes the divider chain
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(div_vld))
      else $error("divider chain moved during stall");

   // scaled pressure is at most 24 bits wide
   a_scaled_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[127:120] == 8'd0))
      else $error("scaled pressure out of range");

   // a bad divisor gives zero pressure fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[127:64] == 64'd0))
      else $error("pressure not zero on bad divisor");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for baro_temp_press_compensation_core
// Drives raw pressure/temperature words in bursts under several coefficient
// settings and checks every result word against an in-bench compensation
// predictor, in order, with random receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [39:0]   req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [63:0]   csr_wdata = '0;

   localparam int IdleLimit = 4000;

   typedef struct packed {
      logic [31:0] fine;
      logic [31:0] centi;
      logic [31:0] q24;
      logic [31:0] scaled;
      logic        invalid;
   } comp_result_type;

   // Expected-result store with its own copy of the coefficients
   class comp_scoreboard;
      logic [15:0]     coeff[12];  // t1 t2 t3 p1 .. p9
      comp_result_type pending[$];
      int              errors = 0;
      int              checked = 0;
      int              invalid_seen = 0;

      function new();
         foreach (coeff[i]) coeff[i] = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] d);
         case (idx)
            bptc_pkg::CsrTempCoeffs: begin
               coeff[0] = d[15:0]; coeff[1] = d[31:16]; coeff[2] = d[47:32];
            end
            bptc_pkg::CsrPressLow: begin
               coeff[3] = d[15:0];  coeff[4] = d[31:16];
               coeff[5] = d[47:32]; coeff[6] = d[63:48];
            end
            bptc_pkg::CsrPressHigh: begin
               coeff[7] = d[15:0];   coeff[8] = d[31:16];
               coeff[9] = d[47:32];  coeff[10] = d[63:48];
            end
            bptc_pkg::CsrPressNine: coeff[11] = d[15:0];
            default: ;
         endcase
      endfunction

      function logic signed [63:0] sx(logic [15:0] v);
         return {{48{v[15]}}, v};
      endfunction

      // signed divide truncating toward zero; most negative / -1 wraps
      function logic [63:0] quot64(logic [63:0] a, logic [63:0] b);
         logic [63:0] ua, ub, q;
         ua = a[63] ? -a : a;
         ub = b[63] ? -b : b;
         q = ua / ub;
         return (a[63] ^ b[63]) ? -q : q;
      endfunction

      function comp_result_type compensate(logic [19:0] raw_p, logic [19:0] raw_t);
         logic signed [31:0] at, t1, t2, t3, a, m, tv1, d, tv2, tf;
         logic signed [63:0] v1, v2, x, p, ps, w1, w2;
         logic [31:0]        m32;
         comp_result_type    r;
         at = {12'b0, raw_t};
         t1 = {16'b0, coeff[0]};
         t2 = {{16{coeff[1][15]}}, coeff[1]};
         t3 = {{16{coeff[2][15]}}, coeff[2]};
         a = (at >> 3) - (t1 << 1);
         m = a * t2;
         tv1 = m >>> 11;
         d = (at >> 4) - t1;
         m = d * d;
         m = m >>> 12;
         m = m * t3;
         tv2 = m >>> 14;
         tf = tv1 + tv2;
         m = tf * 5 + 128;
         r.fine = tf;
         r.centi = m >>> 8;
         // 64-bit pressure path
         v1 = 64'(tf);
         v1 = v1 - bptc_pkg::FineOffset;
         v2 = v1 * v1 * sx(coeff[8]);
         x = v1 * sx(coeff[7]);
         v2 = v2 + (x <<< 17);
         v2 = v2 + (sx(coeff[6]) <<< 35);
         x = v1 * v1 * sx(coeff[5]);
         w1 = v1 * sx(coeff[4]);
         v1 = (x >>> 8) + (w1 <<< 12);
         x = $signed(bptc_pkg::PressBias) + v1;
         x = x * $signed({48'b0, coeff[3]});
         v1 = x >>> 33;
         r.q24 = '0;
         r.invalid = 1'b1;
         if (v1 != 0) begin
            p = 64'(bptc_pkg::PressBase);
            p = p - $signed({44'b0, raw_p});
            x = (p <<< 31) - v2;
            x = x * bptc_pkg::PressScale;
            p = quot64(x, v1);
            ps = p >>> 13;
            x = sx(coeff[11]) * ps * ps;
            w1 = x >>> 25;
            x = sx(coeff[10]) * p;
            w2 = x >>> 19;
            x = p + w1 + w2;
            p = (x >>> 8) + (sx(coeff[9]) <<< 4);
            r.q24 = p[31:0];
            r.invalid = 1'b0;
         end
         m32 = r.q24 * 32'd100;
         r.scaled = m32 >> 8;
         return r;
      endfunction

      function void note_input(logic [39:0] w);
         pending.push_back(compensate(w[19:0], w[39:20]));
      endfunction

      function void check_result(logic [127:0] w, logic inv);
         comp_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: result word with nothing expected: %h", $time, w);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (inv) invalid_seen++;
         if (w[31:0] !== e.fine) begin
            $display("%0t: fine_temperature exp %h got %h", $time, e.fine, w[31:0]);
            errors++;
         end
         if (w[63:32] !== e.centi) begin
            $display("%0t: temperature_centi exp %h got %h", $time, e.centi, w[63:32]);
            errors++;
         end
         if (w[95:64] !== e.q24) begin
            $display("%0t: pressure_q24_8 exp %h got %h", $time, e.q24, w[95:64]);
            errors++;
         end
         if (w[127:96] !== e.scaled) begin
            $display("%0t: pressure_scaled exp %h got %h", $time, e.scaled, w[127:96]);
            errors++;
         end
         if (inv !== e.invalid) begin
            $display("%0t: pressure_invalid exp %b got %b", $time, e.invalid, inv);
            errors++;
         end
      endfunction
   endclass

   comp_scoreboard sb = new();
   int             idle_cycles = 0;
   int             stall_mode = 0;
   int             stall_cnt = 0;

   baro_temp_press_compensation_core dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitor: note accepted inputs, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver stall pattern and watchdog
   always @(posedge clock) begin
      if (stall_cnt == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_cnt <= $urandom_range(10, 120);
      end else begin
         stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (stall_cnt % 8 < 3);
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no traffic for %0d cycles", IdleLimit);
         $display("status: fail");
         $finish;
      end
   end

   // One register write; the caller drops csr_we after the last one
   task automatic csr_write(logic [1:0] idx, logic [63:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   task automatic load_coeffs(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9);
      csr_write(bptc_pkg::CsrTempCoeffs, {16'b0, t});
      csr_write(bptc_pkg::CsrPressLow, pl);
      csr_write(bptc_pkg::CsrPressHigh, ph);
      csr_write(bptc_pkg::CsrPressNine, {48'b0, p9});
      csr_we <= 1'b0;
   endtask

   // One word, held until accepted; valid stays high for the next one
   task automatic send_word(logic [19:0] raw_p, logic [19:0] raw_t);
      req_tvalid <= 1'b1;
      req_tdata <= {raw_t, raw_p};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   // Random run in bursts; about half plausible sensor readings
   task automatic send_random(int count);
      int burst;
      logic [19:0] rp, rt;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            if ($urandom_range(0, 1) != 0) begin
               rp = 20'($urandom_range(200000, 600000));
               rt = 20'($urandom_range(400000, 600000));
            end else begin
               rp = 20'($urandom());
               rt = 20'($urandom());
            end
            send_word(rp, rt);
            burst--;
            count--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients: divisor is zero, pressure flagged invalid
      send_word(20'd0, 20'd0);
      send_word(20'hFFFFF, 20'hFFFFF);
      send_word(20'd415148, 20'd519888);
      drain();

      // Typical factory coefficients
      load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                  {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      send_word(20'd415148, 20'd519888);
      send_word(20'd0, 20'd0);
      send_word(20'hFFFFF, 20'hFFFFF);
      send_word(20'd0, 20'hFFFFF);
      send_word(20'hFFFFF, 20'd0);
      send_word(20'h80000, 20'h80000);
      send_word(20'h55555, 20'hAAAAA);
      send_word(20'hAAAAA, 20'h55555);
      drain();

      // P1 zero: invalid with valid temperature fields
      csr_write(bptc_pkg::CsrPressLow, {16'd2855, 16'd3024, 16'hD843, 16'd0});
      csr_we <= 1'b0;
      send_word(20'd415148, 20'd519888);
      send_word(20'd12345, 20'd600000);
      drain();

      // All-ones, most-negative and most-positive coefficient extremes
      load_coeffs('1, '1, '1, 16'hFFFF);
      send_word(20'd0, 20'd0);
      send_word(20'hFFFFF, 20'hFFFFF);
      send_word(20'd415148, 20'd519888);
      drain();
      load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
                  {4{16'h8000}}, 16'h8000);
      send_word(20'd0, 20'hFFFFF);
      send_word(20'hFFFFF, 20'd0);
      send_word(20'd415148, 20'd519888);
      drain();
      load_coeffs({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
                  {4{16'h7FFF}}, 16'h7FFF);
      send_word(20'd0, 20'd0);
      send_word(20'hFFFFF, 20'hFFFFF);
      drain();

      // Typical coefficients with random readings
      load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                  {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      send_random(250);
      drain();

      // Random coefficient sets
      repeat (4) begin
         load_coeffs(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, 16'($urandom()));
         send_random(150);
         drain();
      end

      $display("checked %0d result words over several coefficient sets, %0d invalid",
               sb.checked, sb.invalid_seen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d words missing", sb.errors, sb.pending.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
